>>> rtl/core/tclru_pkg.sv
// shared types and constants for the tile cache lru lookup
`default_nettype none
package tclru_pkg;

  localparam int unsigned COORD_W  = 11;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned FRAME_W  = 16;
  localparam int unsigned COUNT_W  = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PIX_W    = 21;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned SLOT_W   = 6;

  localparam logic [SIZE_W-1:0]  TILE_EDGE_RST    = 11'd1024;
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 16'd1024;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 16'd1024;
  localparam logic [COUNT_W-1:0] SLOTS_IN_USE_RST = 6'd12;

  typedef enum logic [1:0] {
    STAT_HIT    = 2'd0,
    STAT_FILL   = 2'd1,
    STAT_BAD    = 2'd2,
    STAT_NOSLOT = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_EDGE    = 2'd0,
    CFG_FRAME_WIDTH  = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2,
    CFG_SLOTS_IN_USE = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [SIZE_W-1:0]  width;
    logic [SIZE_W-1:0]  height;
    logic [STAMP_W-1:0] stamp;
  } slot_t;

  typedef struct packed {
    logic  en;
    logic  stamp_only;
    slot_t data;
  } wr_t;

  typedef struct packed {
    logic              hit;
    logic [SIZE_W-1:0] hit_width;
    logic [SIZE_W-1:0] hit_height;
    logic              found;
  } scan_res_t;

endpackage
`default_nettype wire

>>> rtl/core/tile_cache_lru_lookup.sv
// top level of the tile cache lookup: config, sequencer, slot ring, fill math
// requests: a new request is taken only after the previous one is through, which is set by
// one full rotation of the slot ring past the compare cell, one slot per cycle
// the result strobe lasts one cycle and cannot be stalled; start is taken again in that cycle
// reset: all slots invalid, stamp counter zero, registers at defaults; no clearing pass
`default_nettype none
module tile_cache_lru_lookup #(
  parameter int unsigned MAX_SLOTS = 48
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic signed [10:0]               tile_col_i,
  input  wire logic signed [10:0]               tile_row_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [tclru_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [tclru_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                  result_valid_o,
  output logic [1:0]                            status_o,
  output logic [5:0]                            slot_o,
  output logic [10:0]                           width_px_o,
  output logic [10:0]                           height_px_o,
  output logic [31:0]                           fill_offset_o
);

  localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CMP_W = (IDX_W > tclru_pkg::COUNT_W) ? IDX_W : tclru_pkg::COUNT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);
  localparam int unsigned PIX_W = tclru_pkg::PIX_W;
  localparam int unsigned PROD_W = PIX_W + tclru_pkg::FRAME_W;

  // config registers
  logic [tclru_pkg::SIZE_W-1:0]  edge_q;
  logic [tclru_pkg::FRAME_W-1:0] fw_q;
  logic [tclru_pkg::FRAME_W-1:0] fh_q;
  logic [tclru_pkg::COUNT_W-1:0] slots_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q  <= tclru_pkg::TILE_EDGE_RST;
      fw_q    <= tclru_pkg::FRAME_WIDTH_RST;
      fh_q    <= tclru_pkg::FRAME_HEIGHT_RST;
      slots_q <= tclru_pkg::SLOTS_IN_USE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (tclru_pkg::cfg_idx_e'(cfg_idx_i))
        tclru_pkg::CFG_TILE_EDGE:    edge_q  <= cfg_data_i[tclru_pkg::SIZE_W-1:0];
        tclru_pkg::CFG_FRAME_WIDTH:  fw_q    <= cfg_data_i[tclru_pkg::FRAME_W-1:0];
        tclru_pkg::CFG_FRAME_HEIGHT: fh_q    <= cfg_data_i[tclru_pkg::FRAME_W-1:0];
        tclru_pkg::CFG_SLOTS_IN_USE: slots_q <= cfg_data_i[tclru_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  tclru_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0] k_q, k_d;
  logic in_scan, in_done, accept;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      tclru_pkg::ST_IDLE: if (accept) state_d = tclru_pkg::ST_SCAN;
      tclru_pkg::ST_SCAN: if (k_q == LAST_IDX) state_d = tclru_pkg::ST_DONE;
      tclru_pkg::ST_DONE: state_d = tclru_pkg::ST_IDLE;
      default:            state_d = tclru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    in_scan = 1'b0;
    in_done = 1'b0;
    case (state_q)
      tclru_pkg::ST_IDLE: busy = 1'b0;
      tclru_pkg::ST_SCAN: in_scan = 1'b1;
      tclru_pkg::ST_DONE: in_done = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  always_comb begin
    k_d = k_q;
    if (in_scan) begin
      k_d = (k_q == LAST_IDX) ? '0 : k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tclru_pkg::ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // request and fill arithmetic
  logic [tclru_pkg::COORD_W-1:0] col_q, row_q;
  logic [PIX_W-1:0]              tx_q, ty_q;
  logic [PROD_W-1:0]             prod;
  logic [tclru_pkg::OFFSET_W-1:0] off_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= tile_col_i;
      row_q <= tile_row_i;
    end
  end

  assign prod = PROD_W'(ty_q) * PROD_W'(fw_q);

  always_ff @(posedge clk_i) begin
    tx_q  <= PIX_W'(col_q[tclru_pkg::COORD_W-2:0]) * PIX_W'(edge_q);
    ty_q  <= PIX_W'(row_q[tclru_pkg::COORD_W-2:0]) * PIX_W'(edge_q);
    off_q <= prod[tclru_pkg::OFFSET_W-1:0] + tclru_pkg::OFFSET_W'(tx_q);
  end

  // slot ring
  tclru_pkg::slot_t ring [MAX_SLOTS];
  tclru_pkg::wr_t   wr;
  logic [IDX_W-1:0] wr_idx;

  for (genvar p = 0; p < MAX_SLOTS; p++) begin : g_cell
    tclru_pkg::slot_t nxt;
    if (p == MAX_SLOTS - 1) begin : g_wrap
      assign nxt = ring[0];
    end else begin : g_link
      assign nxt = ring[p+1];
    end
    tclru_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (p)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (in_scan),
      .next_i   (nxt),
      .wr_i     (wr),
      .wr_idx_i (wr_idx),
      .slot_o   (ring[p])
    );
  end

  tclru_pkg::scan_res_t res;
  logic [IDX_W-1:0] hit_idx, vic_idx;
  logic active;

  assign active = CMP_W'(k_q) < CMP_W'(slots_q);

  tclru_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .init_i    (accept),
    .step_i    (in_scan && active),
    .idx_i     (k_q),
    .head_i    (ring[0]),
    .col_i     (col_q),
    .row_i     (row_q),
    .res_o     (res),
    .hit_idx_o (hit_idx),
    .vic_idx_o (vic_idx)
  );

  // final decision
  logic [tclru_pkg::STAMP_W-1:0] cnt_q, cnt_d, stamp_new;
  logic                          neg, out_x, out_y;
  logic [PIX_W:0]                x_end, y_end;
  logic [tclru_pkg::SIZE_W-1:0]  tw, th;
  tclru_pkg::status_e            status_d;
  logic [5:0]                    slot_d;
  logic [10:0]                   w_d, h_d;
  logic [31:0]                   off_d;

  assign stamp_new = cnt_q + 1'b1;
  assign neg   = col_q[tclru_pkg::COORD_W-1] | row_q[tclru_pkg::COORD_W-1];
  assign out_x = (PIX_W+1)'(tx_q) >= (PIX_W+1)'(fw_q);
  assign out_y = (PIX_W+1)'(ty_q) >= (PIX_W+1)'(fh_q);
  assign x_end = (PIX_W+1)'(tx_q) + (PIX_W+1)'(edge_q);
  assign y_end = (PIX_W+1)'(ty_q) + (PIX_W+1)'(edge_q);

  always_comb begin
    tw = edge_q;
    th = edge_q;
    if (x_end > (PIX_W+1)'(fw_q)) tw = tclru_pkg::SIZE_W'(fw_q - tclru_pkg::FRAME_W'(tx_q));
    if (y_end > (PIX_W+1)'(fh_q)) th = tclru_pkg::SIZE_W'(fh_q - tclru_pkg::FRAME_W'(ty_q));
  end

  always_comb begin
    status_d = tclru_pkg::STAT_BAD;
    slot_d   = '0;
    w_d      = '0;
    h_d      = '0;
    off_d    = '0;
    wr       = '0;
    wr_idx   = vic_idx;
    cnt_d    = cnt_q;
    if (!neg && res.hit) begin
      status_d           = tclru_pkg::STAT_HIT;
      slot_d             = 6'(hit_idx);
      w_d                = res.hit_width;
      h_d                = res.hit_height;
      wr_idx             = hit_idx;
      wr.en              = in_done;
      wr.stamp_only      = 1'b1;
      wr.data.stamp      = stamp_new;
      cnt_d              = in_done ? stamp_new : cnt_q;
    end else if (!neg && !res.found) begin
      status_d = tclru_pkg::STAT_NOSLOT;
    end else if (!neg && !out_x && !out_y) begin
      status_d       = tclru_pkg::STAT_FILL;
      slot_d         = 6'(vic_idx);
      w_d            = tw;
      h_d            = th;
      off_d          = off_q;
      wr.en          = in_done;
      wr.data.valid  = 1'b1;
      wr.data.col    = col_q;
      wr.data.row    = row_q;
      wr.data.width  = tw;
      wr.data.height = th;
      wr.data.stamp  = stamp_new;
      cnt_d          = in_done ? stamp_new : cnt_q;
    end
  end

  logic result_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q          <= '0;
      result_valid_q <= 1'b0;
    end else begin
      cnt_q          <= cnt_d;
      result_valid_q <= in_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_done) begin
      status_o      <= status_d;
      slot_o        <= slot_d;
      width_px_o    <= w_d;
      height_px_o   <= h_d;
      fill_offset_o <= off_d;
    end
  end

  assign result_valid_o = result_valid_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !result_valid_o))
    else $error("accepted request did not start a scan");

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tclru_pkg::ST_DONE) |-> (k_q == '0))
    else $error("slot ring not at home position at write");

  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == tclru_pkg::STAT_BAD || status_o == tclru_pkg::STAT_NOSLOT))
    |-> (slot_o == '0 && width_px_o == '0 && height_px_o == '0 && fill_offset_o == '0))
    else $error("rejected request carries nonzero fields");

endmodule
`default_nettype wire

>>> rtl/core/tclru_cell.sv
// one slot of the rotating tag ring
`default_nettype none
module tclru_cell #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              shift_i,
  input  wire tclru_pkg::slot_t  next_i,
  input  wire tclru_pkg::wr_t    wr_i,
  input  wire logic [IDX_W-1:0]  wr_idx_i,
  output tclru_pkg::slot_t       slot_o
);

  tclru_pkg::slot_t slot_q, slot_d;
  logic sel;

  assign sel = wr_i.en && (wr_idx_i == IDX_W'(CELL_IDX));

  always_comb begin
    slot_d = slot_q;
    if (sel) begin
      if (wr_i.stamp_only) begin
        slot_d.stamp = wr_i.data.stamp;
      end else begin
        slot_d = wr_i.data;
      end
    end else if (shift_i) begin
      slot_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

>>> rtl/core/tclru_scan.sv
// head-of-ring tag compare and lru victim tracker
`default_nettype none
module tclru_scan #(
  parameter int unsigned IDX_W = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          init_i,
  input  wire logic                          step_i,
  input  wire logic [IDX_W-1:0]              idx_i,
  input  wire tclru_pkg::slot_t              head_i,
  input  wire logic [tclru_pkg::COORD_W-1:0] col_i,
  input  wire logic [tclru_pkg::COORD_W-1:0] row_i,
  output tclru_pkg::scan_res_t               res_o,
  output logic [IDX_W-1:0]                   hit_idx_o,
  output logic [IDX_W-1:0]                   vic_idx_o
);

  tclru_pkg::scan_res_t res_q, res_d;
  logic                            stop_q, stop_d;
  logic [IDX_W-1:0]                hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]                vic_idx_q, vic_idx_d;
  logic [tclru_pkg::STAMP_W-1:0]   vic_stamp_q, vic_stamp_d;
  logic                            match;

  assign match = head_i.valid && (head_i.col == col_i) && (head_i.row == row_i);

  always_comb begin
    res_d       = res_q;
    stop_d      = stop_q;
    hit_idx_d   = hit_idx_q;
    vic_idx_d   = vic_idx_q;
    vic_stamp_d = vic_stamp_q;
    if (init_i) begin
      res_d  = '0;
      stop_d = 1'b0;
    end else if (step_i) begin
      if (!res_q.hit && match) begin
        res_d.hit        = 1'b1;
        res_d.hit_width  = head_i.width;
        res_d.hit_height = head_i.height;
        hit_idx_d        = idx_i;
      end
      if (!stop_q) begin
        if (!head_i.valid) begin
          vic_idx_d   = idx_i;
          res_d.found = 1'b1;
          stop_d      = 1'b1;
        end else if (!res_q.found || (head_i.stamp < vic_stamp_q)) begin
          vic_idx_d   = idx_i;
          vic_stamp_d = head_i.stamp;
          res_d.found = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q  <= '0;
      stop_q <= 1'b0;
    end else begin
      res_q  <= res_d;
      stop_q <= stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q   <= hit_idx_d;
    vic_idx_q   <= vic_idx_d;
    vic_stamp_q <= vic_stamp_d;
  end

  assign res_o     = res_q;
  assign hit_idx_o = hit_idx_q;
  assign vic_idx_o = vic_idx_q;

endmodule
`default_nettype wire
